/* rtl/core/pgoc_pkg.sv */
// Types, codes and widths shared by the gain/offset calibrator files.
`timescale 1ns / 1ps
package pgoc_pkg;

    localparam int DATA_W      = 32;
    localparam int DITHER_W    = 8;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TUSER_W = 2;
    localparam int OUT_TDATA_W = 128;
    localparam int V2_W        = 33;
    localparam int DIFF_W      = 42;
    localparam int MULB_W      = 34;
    localparam int PROD_W      = 66;
    localparam int ACC_W       = 75;
    localparam int SHIFTED_W   = ACC_W - 24;
    localparam int NUM_W       = 64;
    localparam int DEN_W       = 48;
    localparam int REM_W       = 49;
    localparam int QUOT_W      = 33;
    localparam int DIV_CNT_W   = 6;
    localparam int DITHER_MID  = 128;

    typedef logic [2:0] req_t;
    localparam req_t REQ_LOAD    = 3'd0;
    localparam req_t REQ_UPDATE  = 3'd1;
    localparam req_t REQ_READ    = 3'd2;
    localparam req_t REQ_FORWARD = 3'd3;
    localparam req_t REQ_INVERSE = 3'd4;

    typedef logic [1:0] status_t;
    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_MISSING   = 2'd1;
    localparam status_t STAT_ZERO_GAIN = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] quad;
        logic [DATA_W-1:0] gain;
        logic [DATA_W-1:0] offset;
    } coef_t;

    localparam int COEF_W = $bits(coef_t);

endpackage

/* rtl/core/pgoc_ram.sv */
// Generic single-write, single-read RAM with registered read.
`timescale 1ns / 1ps
module pgoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/per_channel_gain_offset_calibrator_core.sv */
// Per-channel gain/offset calibrator: coefficient table, sequencer and shared arithmetic.
// One item at a time; the next is taken in the cycle after the result is registered.
// Inverse uses the restoring divider, one quotient bit per cycle over 33 bits.
// After reset a clearing pass over all 2^(CRATE_BITS+SLOT_BITS+CHANNEL_BITS) entries (32768 by
// default) empties the valid store; no transaction is taken until it ends.
`timescale 1ns / 1ps
module per_channel_gain_offset_calibrator_core #(
    parameter int CRATE_BITS   = 4,
    parameter int SLOT_BITS    = 5,
    parameter int CHANNEL_BITS = 6,
    localparam int IDX_W       = CRATE_BITS + SLOT_BITS + CHANNEL_BITS,
    localparam int IN_FIELD_W  = IDX_W + 32 + 1 + 8 + 96,
    localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // crate, slot, channel, value, smear, dither, par_offset, par_gain, par_quad
    input  logic [IN_TDATA_W-1:0]              s_tdata,
    // req_type, kind
    input  logic [pgoc_pkg::IN_TUSER_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // result_value, read_offset, read_gain, read_quad
    output logic [pgoc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // status
    output logic [pgoc_pkg::OUT_TUSER_W-1:0]   m_tuser
);
    import pgoc_pkg::*;

    localparam int DEPTH      = 1 << IDX_W;
    localparam int SLOT_LSB   = CRATE_BITS;
    localparam int CHAN_LSB   = CRATE_BITS + SLOT_BITS;
    localparam int VALUE_LSB  = IDX_W;
    localparam int SMEAR_BIT  = IDX_W + 32;
    localparam int DITHER_LSB = IDX_W + 33;
    localparam int OFF_LSB    = IDX_W + 41;
    localparam int GAIN_LSB   = IDX_W + 73;
    localparam int QUAD_LSB   = IDX_W + 105;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LOOK, S_MUL1, S_MUL2, S_ACC, S_FIN,
        S_NUM, S_ABS, S_CHK, S_DIV, S_QFIN, S_OUT
    } state_t;

    state_t                   state_reg;
    logic [IDX_W-1:0]         clr_cnt_reg;
    req_t                     req_reg;
    logic                     kind_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [DATA_W-1:0] v_reg;
    logic signed [V2_W-1:0]   v2_reg;
    coef_t                    par_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]         mag_reg;
    logic [DEN_W-1:0]         den_reg;
    logic                     neg_reg;
    logic                     ovf_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [QUOT_W-1:0]        nsh_reg;
    logic [QUOT_W-1:0]        q_reg;
    logic [DIV_CNT_W-1:0]     cnt_reg;
    status_t                  status_reg;
    logic [DATA_W-1:0]        res_reg;
    coef_t                    rd_reg;
    logic                     m_tvalid_reg;
    status_t                  m_status_reg;
    logic [OUT_TDATA_W-1:0]   m_data_reg;

    logic                     s_accept;
    logic [IDX_W-1:0]         s_idx;
    coef_t                    ent;
    logic                     found;
    logic                     tab_we;
    logic                     val_we;
    logic [IDX_W-1:0]         val_waddr;
    logic                     val_wdata;
    logic signed [DATA_W-1:0] gain_s;
    logic signed [DATA_W-1:0] off_s;
    logic signed [MULB_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [V2_W-1:0]   s_value;
    logic signed [V2_W-1:0]   s_dith;
    logic signed [V2_W-1:0]   v_trunc;
    logic signed [DEN_W-1:0]  den_s;
    logic [REM_W-1:0]         rem_sh;
    logic                     q_bit;
    logic                     ovf;

    function automatic logic [DATA_W-1:0] sat32(input logic signed [SHIFTED_W-1:0] x);
        if (x[SHIFTED_W-1:DATA_W-1] == '0 || x[SHIFTED_W-1:DATA_W-1] == '1) begin
            return x[DATA_W-1:0];
        end
        return x[SHIFTED_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_idx     = {s_tdata[SLOT_LSB-1:0], s_tdata[CHAN_LSB-1:SLOT_LSB],
                        s_tdata[IDX_W-1:CHAN_LSB]};
    assign gain_s    = $signed(ent.gain);
    assign off_s     = $signed(ent.offset);
    assign s_value   = V2_W'($signed(s_tdata[VALUE_LSB +: DATA_W]));
    assign s_dith    = V2_W'(s_tdata[DITHER_LSB +: DITHER_W]) - V2_W'(DITHER_MID);
    assign v_trunc   = (V2_W'(v_reg) + (v_reg[DATA_W-1] ? V2_W'(255) : V2_W'(0))) >>> 8;

    assign tab_we    = (state_reg == S_LOOK) &&
                       (req_reg == REQ_LOAD || (req_reg == REQ_UPDATE && found));
    assign val_we    = (state_reg == S_CLR) || (state_reg == S_LOOK && req_reg == REQ_LOAD);
    assign val_waddr = (state_reg == S_CLR) ? clr_cnt_reg : idx_reg;
    assign val_wdata = (state_reg != S_CLR);

    pgoc_ram #(.WIDTH(COEF_W), .DEPTH(DEPTH)) u_tab_ram (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (idx_reg),
        .wdata (par_reg),
        .re    (s_accept),
        .raddr (s_idx),
        .rdata (ent)
    );

    pgoc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .re    (s_accept),
        .raddr (s_idx),
        .rdata (found)
    );

    // shared multiplier: gain times a selected operand
    always_comb begin
        mul_b = MULB_W'($signed({1'b0, diff_reg[15:0]}));
        if (state_reg == S_MUL1) begin
            if (req_reg == REQ_INVERSE) begin
                mul_b = MULB_W'(off_s);
            end else if (kind_reg) begin
                mul_b = MULB_W'(v2_reg);
            end else begin
                mul_b = MULB_W'($signed(diff_reg[DIFF_W-1:16]));
            end
        end
        prod = gain_s * mul_b;
    end

    always_comb begin
        den_s  = kind_reg ? DEN_W'(gain_s) : (DEN_W'(gain_s) <<< 16);
        rem_sh = {rem_reg[REM_W-2:0], nsh_reg[QUOT_W-1]};
        q_bit  = (rem_sh >= {1'b0, den_reg});
        ovf    = ({{(DEN_W-31){1'b0}}, mag_reg[NUM_W-1:QUOT_W]} >= den_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == '1) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_accept) begin
                        req_reg    <= s_tuser[2:0];
                        kind_reg   <= s_tuser[3];
                        idx_reg    <= s_idx;
                        v_reg      <= $signed(s_tdata[VALUE_LSB +: DATA_W]);
                        v2_reg     <= s_tdata[SMEAR_BIT] ? s_value + s_dith : s_value;
                        par_reg    <= {s_tdata[QUAD_LSB +: DATA_W], s_tdata[GAIN_LSB +: DATA_W],
                                       s_tdata[OFF_LSB +: DATA_W]};
                        status_reg <= STAT_OK;
                        res_reg    <= '0;
                        rd_reg     <= '0;
                        state_reg  <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    unique case (req_reg)
                        REQ_LOAD: state_reg <= S_OUT;
                        REQ_UPDATE, REQ_READ: begin
                            if (!found) begin
                                status_reg <= STAT_MISSING;
                            end else if (req_reg == REQ_READ) begin
                                rd_reg <= ent;
                            end
                            state_reg <= S_OUT;
                        end
                        REQ_FORWARD: begin
                            if (!found) begin
                                res_reg    <= v_reg;
                                status_reg <= STAT_MISSING;
                                state_reg  <= S_OUT;
                            end else begin
                                diff_reg  <= (DIFF_W'(v2_reg) <<< 8) - DIFF_W'(off_s);
                                state_reg <= S_MUL1;
                            end
                        end
                        REQ_INVERSE: begin
                            if (!found) begin
                                res_reg    <= v_trunc[DATA_W-1:0];
                                status_reg <= STAT_MISSING;
                                state_reg  <= S_OUT;
                            end else if (ent.gain == '0) begin
                                status_reg <= STAT_ZERO_GAIN;
                                state_reg  <= S_OUT;
                            end else begin
                                state_reg <= kind_reg ? S_NUM : S_MUL1;
                            end
                        end
                        default: state_reg <= S_OUT;
                    endcase
                end
                S_MUL1: begin
                    prod_reg  <= prod;
                    state_reg <= (req_reg == REQ_INVERSE) ? S_NUM : S_MUL2;
                end
                S_MUL2: begin
                    if (kind_reg) begin
                        acc_reg   <= (ACC_W'(prod_reg) - (ACC_W'(off_s) <<< 8)
                                      + ACC_W'(1 << 15)) <<< 8;
                        state_reg <= S_FIN;
                    end else begin
                        acc_reg   <= ACC_W'(prod_reg) <<< 16;
                        prod_reg  <= prod;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    acc_reg   <= acc_reg + ACC_W'(prod_reg) + ACC_W'(1 << 23);
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    res_reg   <= sat32(SHIFTED_W'(acc_reg >>> 24));
                    state_reg <= S_OUT;
                end
                S_NUM: begin
                    if (kind_reg) begin
                        num_reg <= (NUM_W'(v_reg) <<< 8) + NUM_W'(off_s);
                    end else begin
                        num_reg <= (NUM_W'(v_reg) <<< 24) + NUM_W'(prod_reg);
                    end
                    state_reg <= S_ABS;
                end
                S_ABS: begin
                    mag_reg   <= num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
                    den_reg   <= gain_s[DATA_W-1] ? DEN_W'(-den_s) : DEN_W'(den_s);
                    neg_reg   <= num_reg[NUM_W-1] ^ gain_s[DATA_W-1];
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    ovf_reg   <= ovf;
                    rem_reg   <= REM_W'(mag_reg[NUM_W-1:QUOT_W]);
                    nsh_reg   <= mag_reg[QUOT_W-1:0];
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ovf ? S_QFIN : S_DIV;
                end
                S_DIV: begin
                    rem_reg <= q_bit ? rem_sh - {1'b0, den_reg} : rem_sh;
                    q_reg   <= {q_reg[QUOT_W-2:0], q_bit};
                    nsh_reg <= {nsh_reg[QUOT_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_CNT_W'(QUOT_W - 1)) begin
                        state_reg <= S_QFIN;
                    end
                end
                S_QFIN: begin
                    if (neg_reg) begin
                        if (ovf_reg || q_reg[QUOT_W-1] || (q_reg[31] && (|q_reg[30:0]))) begin
                            res_reg <= {1'b1, {(DATA_W-1){1'b0}}};
                        end else begin
                            res_reg <= -q_reg[DATA_W-1:0];
                        end
                    end else if (ovf_reg || q_reg[QUOT_W-1] || q_reg[31]) begin
                        res_reg <= {1'b0, {(DATA_W-1){1'b1}}};
                    end else begin
                        res_reg <= q_reg[DATA_W-1:0];
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= status_reg;
                        m_data_reg   <= {rd_reg.quad, rd_reg.gain, rd_reg.offset, res_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    a_no_accept_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("transaction taken while busy");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_MISSING ||
                      m_tuser == STAT_ZERO_GAIN))
        else $error("bad status code");

    a_zero_gain_res: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STAT_ZERO_GAIN) |-> (m_tdata[DATA_W-1:0] == '0))
        else $error("zero gain result not cleared");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (cnt_reg < DIV_CNT_W'(QUOT_W)))
        else $error("divider ran past its last step");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the per-channel gain/offset calibrator core.
`timescale 1ns / 1ps
module testbench;
    import pgoc_pkg::*;

    localparam int  ITEMS      = 1400;
    localparam int  POOL       = 24;
    localparam longint CYC_MAX = 1000000;

    typedef struct {
        req_t         req;
        logic [3:0]   crate;
        logic [4:0]   slot;
        logic [5:0]   channel;
        logic         kind;
        logic [31:0]  value;
        logic         smear;
        logic [7:0]   dither;
        logic [31:0]  par_offset;
        logic [31:0]  par_gain;
        logic [31:0]  par_quad;
    } cal_req_t;

    typedef struct {
        status_t      status;
        logic [31:0]  result_value;
        logic [31:0]  read_offset;
        logic [31:0]  read_gain;
        logic [31:0]  read_quad;
    } cal_res_t;

    logic          aclk = 0;
    logic          aresetn = 0;
    logic          s_tvalid = 0;
    logic          s_tready;
    logic [151:0]  s_tdata = '0;
    logic [3:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 0;
    logic [127:0]  m_tdata;
    logic [1:0]    m_tuser;

    cal_res_t      pending_results[$];
    longint        tbl_offset[int];
    longint        tbl_gain[int];
    longint        tbl_quad[int];
    bit            tbl_valid[int];
    logic [14:0]   idx_pool[POOL];
    bit            no_idle = 0;
    bit            hold_go = 0;
    int            hold_left = 0;
    int            errors = 0;
    longint        cycles = 0;

    per_channel_gain_offset_calibrator_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic longint sat32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Updates the shadow table and works out the result of one request.
    function automatic cal_res_t calibrate(input cal_req_t it);
        cal_res_t r;
        int     idx;
        bit     found;
        longint v, v2, g, o, diff, hi, lo, y, x, num, den;
        idx = int'({it.crate, it.slot, it.channel});
        found = tbl_valid.exists(idx);
        v = longint'(signed'(it.value));
        r = '{STAT_OK, '0, '0, '0, '0};
        g = found ? tbl_gain[idx] : 0;
        o = found ? tbl_offset[idx] : 0;
        case (it.req)
            REQ_LOAD, REQ_UPDATE: begin
                if (it.req == REQ_LOAD || found) begin
                    tbl_offset[idx] = longint'(signed'(it.par_offset));
                    tbl_gain[idx]   = longint'(signed'(it.par_gain));
                    tbl_quad[idx]   = longint'(signed'(it.par_quad));
                    tbl_valid[idx]  = 1;
                end else r.status = STAT_MISSING;
            end
            REQ_READ: begin
                if (found) begin
                    r.read_offset = o[31:0];
                    r.read_gain   = g[31:0];
                    r.read_quad   = tbl_quad[idx][31:0];
                end else r.status = STAT_MISSING;
            end
            REQ_FORWARD: begin
                if (!found) begin
                    r.status = STAT_MISSING;
                    r.result_value = it.value;
                end else begin
                    v2 = it.smear ? v + longint'(it.dither) - DITHER_MID : v;
                    if (!it.kind) begin
                        diff = v2 * 256 - o;
                        hi = diff >>> 16;
                        lo = diff - hi * 65536;
                        y = g * hi + ((g * lo + (64'sd1 <<< 23)) >>> 16);
                        x = sat32(y >>> 8);
                    end else
                        x = sat32((g * v2 - o * 256 + (64'sd1 <<< 15)) >>> 16);
                    r.result_value = x[31:0];
                end
            end
            REQ_INVERSE: begin
                if (!found) begin
                    r.status = STAT_MISSING;
                    x = v / 256;
                    r.result_value = x[31:0];
                end else if (g == 0)
                    r.status = STAT_ZERO_GAIN;
                else begin
                    if (!it.kind) begin
                        num = v * (64'sd1 <<< 24) + o * g;
                        den = g * 65536;
                    end else begin
                        num = v * 256 + o;
                        den = g;
                    end
                    x = sat32(num / den);
                    r.result_value = x[31:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic bit roll_idle();
        return !no_idle && ($urandom_range(99) < 32);
    endfunction

    task automatic send_item(input cal_req_t it);
        @(negedge aclk);
        while (roll_idle()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {it.par_quad, it.par_gain, it.par_offset, it.dither, it.smear,
                     it.value, it.channel, it.slot, it.crate};
        s_tuser  <= {it.kind, it.req};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(calibrate(it));
    endtask

    function automatic cal_req_t mk(input req_t req, input logic [14:0] idx,
                                    input logic kind, input logic [31:0] value,
                                    input logic [31:0] po, input logic [31:0] pg);
        cal_req_t it;
        it = '{req, idx[14:11], idx[10:6], idx[5:0], kind, value, 1'b0, 8'd0,
               po, pg, $urandom()};
        return it;
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_go && hold_left == 0) begin
            hold_go = 0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else
            m_tready <= !roll_idle();
    end

    always @(posedge aclk) begin
        cal_res_t want;
        cycles++;
        if (cycles > CYC_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction tdata=%h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, m_tuser);
                    errors++;
                end
                if (m_tdata[31:0] !== want.result_value) begin
                    $display("%0t: result exp %h got %h", $time, want.result_value,
                             m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== want.read_offset) begin
                    $display("%0t: offset exp %h got %h", $time, want.read_offset,
                             m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[95:64] !== want.read_gain) begin
                    $display("%0t: gain exp %h got %h", $time, want.read_gain,
                             m_tdata[95:64]);
                    errors++;
                end
                if (m_tdata[127:96] !== want.read_quad) begin
                    $display("%0t: quad exp %h got %h", $time, want.read_quad,
                             m_tdata[127:96]);
                    errors++;
                end
            end
        end
    end

    task automatic test_missing_entries();
        send_item(mk(REQ_READ, 15'h7fff, 0, 32'h0, 32'h0, 32'h0));
        send_item(mk(REQ_UPDATE, 15'h0, 0, 32'h0, 32'h1234, 32'h5678));
        send_item(mk(REQ_FORWARD, 15'h1, 0, 32'h80000000, 32'h0, 32'h0));
        send_item(mk(REQ_INVERSE, 15'h2, 1, 32'hffffff01, 32'h0, 32'h0));
        send_item(mk(REQ_INVERSE, 15'h3, 0, 32'h7fffffff, 32'h0, 32'h0));
    endtask

    task automatic test_load_read();
        send_item(mk(REQ_LOAD, 15'h0, 0, 32'h0, 32'h80000000, 32'h7fffffff));
        send_item(mk(REQ_LOAD, 15'h7fff, 1, 32'h0, 32'h7fffffff, 32'h80000000));
        send_item(mk(REQ_READ, 15'h0, 0, 32'h0, 32'h0, 32'h0));
        send_item(mk(REQ_UPDATE, 15'h7fff, 0, 32'h0, 32'h00010000, 32'h00020000));
        send_item(mk(REQ_READ, 15'h7fff, 1, 32'h0, 32'h0, 32'h0));
    endtask

    task automatic test_forward();
        cal_req_t it;
        send_item(mk(REQ_FORWARD, 15'h0, 0, 32'h7fffffff, 32'h0, 32'h0));
        send_item(mk(REQ_FORWARD, 15'h0, 1, 32'h80000000, 32'h0, 32'h0));
        it = mk(REQ_FORWARD, 15'h7fff, 0, 32'h00001234, 32'h0, 32'h0);
        it.smear = 1; it.dither = 8'hff;
        send_item(it);
        it.kind = 1; it.dither = 8'h00;
        send_item(it);
        send_item(mk(REQ_LOAD, 15'h10, 0, 32'h0, 32'h00008000, 32'h0));
        send_item(mk(REQ_FORWARD, 15'h10, 0, 32'h12345678, 32'h0, 32'h0));
    endtask

    task automatic test_inverse();
        send_item(mk(REQ_INVERSE, 15'h10, 0, 32'h12345678, 32'h0, 32'h0));
        send_item(mk(REQ_INVERSE, 15'h7fff, 0, 32'h80000000, 32'h0, 32'h0));
        send_item(mk(REQ_INVERSE, 15'h7fff, 1, 32'h7fffffff, 32'h0, 32'h0));
        send_item(mk(REQ_INVERSE, 15'h0, 1, 32'hfffff000, 32'h0, 32'h0));
        send_item(mk(REQ_LOAD, 15'h11, 0, 32'h0, 32'h00050000, 32'h00000001));
        send_item(mk(REQ_INVERSE, 15'h11, 0, 32'h7fffffff, 32'h0, 32'h0));
        send_item(mk(REQ_LOAD, 15'h12, 0, 32'h0, 32'h00010000, 32'h0));
        send_item(mk(REQ_INVERSE, 15'h12, 1, 32'h00000100, 32'h0, 32'h0));
        send_item(mk(REQ_FORWARD, 15'h12, 1, 32'h00000100, 32'h0, 32'h0));
    endtask

    task automatic test_unused_codes();
        send_item(mk(req_t'(5), 15'h0, 0, 32'hffffffff, 32'h1, 32'h1));
        send_item(mk(req_t'(6), 15'h10, 1, 32'h1, 32'h1, 32'h1));
        send_item(mk(req_t'(7), 15'h7fff, 1, 32'h80000000, 32'h1, 32'h1));
    endtask

    function automatic cal_req_t random_req();
        cal_req_t it;
        int sel;
        logic [14:0] idx;
        sel = $urandom_range(99);
        idx = ($urandom_range(9) == 0) ? 15'($urandom()) : idx_pool[$urandom_range(POOL-1)];
        it = mk(REQ_LOAD, idx, 1'($urandom_range(1)), $urandom(), $urandom(), $urandom());
        if      (sel < 15) it.req = REQ_LOAD;
        else if (sel < 25) it.req = REQ_UPDATE;
        else if (sel < 40) it.req = REQ_READ;
        else if (sel < 70) it.req = REQ_FORWARD;
        else if (sel < 95) it.req = REQ_INVERSE;
        else               it.req = req_t'($urandom_range(7, 5));
        it.smear  = 1'($urandom_range(1));
        it.dither = 8'($urandom());
        case ($urandom_range(3))
            0: it.par_gain = 32'($signed($urandom_range(0, 262144)) - 131072);
            1: it.par_gain = ($urandom_range(3) == 0) ? 32'h0 : 32'h00010000;
            default: ;
        endcase
        if ($urandom_range(2) == 0) it.value = 32'($signed($urandom_range(0, 65536)) - 32768);
        if ($urandom_range(2) == 0) it.par_offset = 32'($signed($urandom_range(0, 4096)) - 2048);
        return it;
    endfunction

    task automatic test_random_traffic();
        for (int i = 0; i < ITEMS; i++) begin
            no_idle = (i >= 400 && i < 600);
            send_item(random_req());
        end
        no_idle = 0;
    endtask

    task automatic test_backpressure();
        hold_go = 1;
        for (int i = 0; i < 30; i++) send_item(random_req());
    endtask

    initial begin
        for (int i = 0; i < POOL; i++) idx_pool[i] = 15'($urandom());
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_missing_entries();
        test_load_read();
        test_forward();
        test_inverse();
        test_unused_codes();
        test_backpressure();
        test_random_traffic();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
